@@ rtl/ppv_pkg.sv @@
package ppv_pkg;

    localparam int QBITS    = 42;
    localparam int CAP_LOG  = 40;
    localparam int PIPE_LAT = QBITS + 5;
    localparam int CFG_IW   = 4;
    localparam int CFG_DW   = 64;
    localparam int DIM_W    = 14;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ROW_X_LO = 4'd0,
        CFG_ROW_X_HI = 4'd1,
        CFG_ROW_Y_LO = 4'd2,
        CFG_ROW_Y_HI = 4'd3,
        CFG_ROW_W_LO = 4'd4,
        CFG_ROW_W_HI = 4'd5,
        CFG_WIDTH    = 4'd6,
        CFG_HEIGHT   = 4'd7
    } t_cfg_idx;

endpackage

@@ rtl/ppv_div.sv @@
module ppv_div #(
    parameter int NUM_W = 81,
    parameter int DEN_W = 51
) (
    input  logic                        i_clk,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic [ppv_pkg::CAP_LOG:0]   o_quo
);
    import ppv_pkg::*;

    localparam int RW = DEN_W + 1;
    localparam int CW = (NUM_W > DEN_W + QBITS) ? NUM_W : DEN_W + QBITS;
    localparam logic [QBITS-1:0] CAP = QBITS'(1) << CAP_LOG;

    logic [RW-1:0]    r_rem [0:QBITS];
    logic [QBITS-1:0] r_low [0:QBITS];
    logic [QBITS-1:0] r_quo [0:QBITS];
    logic [DEN_W-1:0] r_den [0:QBITS];
    logic             r_ovf [0:QBITS];

    logic [CW-1:0] n_a;
    logic [CW-1:0] n_b;

    assign n_a = CW'(i_num);
    assign n_b = CW'({i_den, {QBITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= n_a >= n_b;
        r_rem[0] <= RW'(i_num >> QBITS);
        r_low[0] <= i_num[QBITS-1:0];
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    genvar k;
    generate
        for (k = 1; k <= QBITS; k++) begin : g_stage
            logic [RW-1:0] n_t;
            logic          n_ge;
            assign n_t  = {r_rem[k-1][RW-2:0], r_low[k-1][QBITS-k]};
            assign n_ge = n_t >= {1'b0, r_den[k-1]};
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_ge ? n_t - {1'b0, r_den[k-1]} : n_t;
                r_quo[k] <= {r_quo[k-1][QBITS-2:0], n_ge};
                r_low[k] <= r_low[k-1];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    endgenerate

    assign o_quo = (r_ovf[QBITS] || r_quo[QBITS] > CAP) ? CAP[CAP_LOG:0]
                                                         : r_quo[QBITS][CAP_LOG:0];

endmodule

@@ rtl/perspective_project_viewport_top.sv @@
// Channel   | Ports                                   | Handshake
// config    | i_cfg_we, i_cfg_idx, i_cfg_data         | write when i_cfg_we high
// request   | start, busy, i_pos_x/y/z                | taken when start && !busy
// result    | o_strobe, o_screen_x/y, o_visible       | one cycle, o_strobe high
//
// One request per cycle; each result passes through the product, dot and
// scale stages, the divider input register and its 42 restoring stages,
// then the output stage.
// busy is high only during reset and the cycle after it.
// The receiver cannot stall, so the pipeline never holds.
module perspective_project_viewport_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppv_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [ppv_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_pos_z,
    output logic                          o_strobe,
    output logic signed [31:0]            o_screen_x,
    output logic signed [31:0]            o_screen_y,
    output logic                          o_visible
);
    import ppv_pkg::*;

    localparam int DW    = 67 - FRAC_BITS;
    localparam int NUM_W = DW + DIM_W + FRAC_BITS;
    localparam int OW    = 48;
    localparam logic signed [DW-1:0] EPS = DW'((1 << FRAC_BITS) / 1000);
    localparam logic signed [OW-1:0] HALF = OW'(1) << (FRAC_BITS - 1);
    localparam logic signed [OW-1:0] SMAX = OW'(32'sh7FFFFFFF);
    localparam logic signed [OW-1:0] SMIN = -OW'(64'sh80000000);

    logic [63:0]      r_row [0:5];
    logic [DIM_W-1:0] r_wd;
    logic [DIM_W-1:0] r_ht;
    logic             r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_row[i] <= '0;
            r_wd  <= DIM_W'(1920);
            r_ht  <= DIM_W'(1080);
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROW_X_LO: r_row[0] <= i_cfg_data;
                    CFG_ROW_X_HI: r_row[1] <= i_cfg_data;
                    CFG_ROW_Y_LO: r_row[2] <= i_cfg_data;
                    CFG_ROW_Y_HI: r_row[3] <= i_cfg_data;
                    CFG_ROW_W_LO: r_row[4] <= i_cfg_data;
                    CFG_ROW_W_HI: r_row[5] <= i_cfg_data;
                    CFG_WIDTH:    r_wd     <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:   r_ht     <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = ~r_rdy;

    // stage 1: products
    logic               r_v1;
    logic signed [63:0] r_p [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_p[r][0] <= $signed(r_row[2*r][31:0])    * i_pos_x;
            r_p[r][1] <= $signed(r_row[2*r][63:32])   * i_pos_y;
            r_p[r][2] <= $signed(r_row[2*r+1][31:0])  * i_pos_z;
        end
    end

    // stage 2: dot products
    logic signed [65:0] n_s [0:2];
    logic signed [DW-1:0] n_d [0:2];
    logic               r_v2;
    logic               r_vis2;
    logic signed [DW-1:0] r_d [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s[r] = 66'(r_p[r][0]) + 66'(r_p[r][1]) + 66'(r_p[r][2]);
            n_d[r] = DW'(n_s[r] >>> FRAC_BITS) + DW'($signed(r_row[2*r+1][63:32]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) r_d[r] <= n_d[r];
        r_vis2 <= n_d[2] > EPS;
    end

    // stage 3: scale by viewport size
    logic [DW-1:0]          n_mx;
    logic [DW-1:0]          n_my;
    logic                   r_v3;
    logic                   r_vis3;
    logic                   r_sgx3;
    logic                   r_sgy3;
    logic [DW+DIM_W-1:0]    r_nx;
    logic [DW+DIM_W-1:0]    r_ny;
    logic [DW-1:0]          r_den;

    assign n_mx = r_d[0][DW-1] ? DW'(-r_d[0]) : DW'(r_d[0]);
    assign n_my = r_d[1][DW-1] ? DW'(-r_d[1]) : DW'(r_d[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        r_vis3 <= r_vis2;
        r_sgx3 <= r_d[0][DW-1];
        r_sgy3 <= r_d[1][DW-1];
        r_nx   <= n_mx * r_wd;
        r_ny   <= n_my * r_ht;
        r_den  <= {r_d[2][DW-2:0], 1'b0};
    end

    // divide
    logic [CAP_LOG:0] n_qx;
    logic [CAP_LOG:0] n_qy;

    ppv_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_x (
        .i_clk (i_clk),
        .i_num ({r_nx, {FRAC_BITS{1'b0}}}),
        .i_den (r_den),
        .o_quo (n_qx)
    );

    ppv_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div_y (
        .i_clk (i_clk),
        .i_num ({r_ny, {FRAC_BITS{1'b0}}}),
        .i_den (r_den),
        .o_quo (n_qy)
    );

    logic r_sv  [0:QBITS];
    logic r_svi [0:QBITS];
    logic r_ssx [0:QBITS];
    logic r_ssy [0:QBITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QBITS; i++) r_sv[i] <= 1'b0;
        end else begin
            r_sv[0] <= r_v3;
            for (int i = 1; i <= QBITS; i++) r_sv[i] <= r_sv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_svi[0] <= r_vis3;
        r_ssx[0] <= r_sgx3;
        r_ssy[0] <= r_sgy3;
        for (int i = 1; i <= QBITS; i++) begin
            r_svi[i] <= r_svi[i-1];
            r_ssx[i] <= r_ssx[i-1];
            r_ssy[i] <= r_ssy[i-1];
        end
    end

    // output stage
    logic signed [OW-1:0] n_tx;
    logic signed [OW-1:0] n_ty;
    logic signed [OW-1:0] n_sx;
    logic signed [OW-1:0] n_sy;
    logic signed [31:0]   n_ox;
    logic signed [31:0]   n_oy;
    logic                 r_strobe;
    logic signed [31:0]   r_ox;
    logic signed [31:0]   r_oy;
    logic                 r_vis;

    always_comb begin
        n_tx = r_ssx[QBITS] ? -OW'(n_qx) : OW'(n_qx);
        n_ty = r_ssy[QBITS] ? -OW'(n_qy) : OW'(n_qy);
        n_sx = (OW'(r_wd >> 1) <<< FRAC_BITS) + (n_tx + HALF);
        n_sy = (OW'(r_ht >> 1) <<< FRAC_BITS) - (n_ty + HALF);
        if (n_sx > SMAX)      n_ox = SMAX[31:0];
        else if (n_sx < SMIN) n_ox = SMIN[31:0];
        else                  n_ox = n_sx[31:0];
        if (n_sy > SMAX)      n_oy = SMAX[31:0];
        else if (n_sy < SMIN) n_oy = SMIN[31:0];
        else                  n_oy = n_sy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= r_sv[QBITS];
    end

    always_ff @(posedge i_clk) begin
        r_vis <= r_svi[QBITS];
        r_ox  <= r_svi[QBITS] ? n_ox : '0;
        r_oy  <= r_svi[QBITS] ? n_oy : '0;
    end

    assign o_strobe   = r_strobe;
    assign o_screen_x = r_ox;
    assign o_screen_y = r_oy;
    assign o_visible  = r_vis;

endmodule

@@ rtl/ppv_chk.sv @@
module ppv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [31:0] o_screen_x,
    input logic [31:0] o_screen_y,
    input logic        o_visible
);
    import ppv_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_visible |-> o_screen_x == 32'd0 && o_screen_y == 32'd0)
        else $error("hidden point not zero");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_LAT o_strobe)
        else $error("result missing");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##PIPE_LAT !o_strobe)
        else $error("unexpected result");

endmodule

bind perspective_project_viewport_top ppv_chk u_ppv_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_screen_x (o_screen_x),
    .o_screen_y (o_screen_y),
    .o_visible  (o_visible)
);
